/* hw/rtl/cal_pkg.sv */
// Shared types and codes for the compacting array list.
`default_nettype none

package cal_pkg;

	// request codes
	localparam logic [2:0] REQ_PUSH        = 3'd0;
	localparam logic [2:0] REQ_POP         = 3'd1;
	localparam logic [2:0] REQ_CLEAR       = 3'd2;
	localparam logic [2:0] REQ_ERASE_INDEX = 3'd3;
	localparam logic [2:0] REQ_ERASE_RANGE = 3'd4;
	localparam logic [2:0] REQ_READ        = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_FIN   = 4'b1000
	} cal_state_t;

endpackage

`default_nettype wire

/* hw/rtl/compacting_array_list.sv */
// Compacting array list: ordered store of signed words with push, pop, clear, erase, read.
// Push, pop, clear, unused codes and rejected requests go straight to the result; a read passes
// through ST_READ; an erase passes through ST_SHIFT, which moves the following words down one by one.
// One request at a time: a new request is taken once the previous result has been loaded
// into the output register, even while that result is still stalled there.
// Reset (arst_n low) empties the list at once; the word memory itself is never cleared.
`default_nettype none

module compacting_array_list #(
	parameter int DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] push_value,
	input  wire logic [7:0]         position,
	input  wire logic [7:0]         range_end,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      read_word,
	output logic [8:0]              entry_count,
	output logic                    is_empty
);

	import cal_pkg::*;

	// AW addresses the memory; CW holds an entry count up to DEPTH itself.
	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	// Compare width: wide enough for both the count and an 8-bit index plus one.
	localparam int CMPW = (CW > 9) ? CW : 9;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// Word store: one write and one registered read per cycle.
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;

	cal_state_t state_q;

	logic [CW-1:0] fill_q;
	// Shift pointers: src reads ahead, dst trails behind it through rdata_q.
	logic [CW-1:0] src_q;
	logic [CW-1:0] dst_q;
	logic          rd_pend_q;

	// Result waiting to be moved into the output register.
	logic [1:0]  res_status_q;
	logic [31:0] res_word_q;

	// Widened views for index checks.
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] end_w;
	logic [CMPW-1:0] fill_w;
	logic            pos_in_range;
	logic            range_ok;
	logic            src_lt;
	logic            in_xfer;
	logic            out_free;

	assign pos_w  = CMPW'(position);
	assign end_w  = CMPW'(range_end);
	assign fill_w = CMPW'(fill_q);

	assign pos_in_range = pos_w < fill_w;
	assign range_ok     = (pos_w <= end_w) && (end_w < fill_w);
	assign src_lt       = src_q < fill_q;

	// Take a new request only in idle; the output register decouples the result side.
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Memory port steering: push writes at the tail, shift writes at dst.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = push_value;
		if (state_q == ST_SHIFT) begin
			mem_we    = rd_pend_q;
			mem_waddr = dst_q[AW-1:0];
			mem_wdata = rdata_q;
		end else if (in_xfer && req_type == REQ_PUSH && fill_q != FULL_CNT) begin
			mem_we = 1'b1;
		end
	end

	// During a shift read at src; otherwise read at the requested position.
	assign mem_raddr = (state_q == ST_SHIFT) ? src_q[AW-1:0] : AW'(position);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Sequencer and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			rd_pend_q    <= 1'b0;
			res_status_q <= STAT_DONE;
			res_word_q   <= '0;
			out_valid    <= 1'b0;
		end else begin
			// drop the output once taken; a new load below overrides this
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						res_status_q <= STAT_DONE;
						res_word_q   <= '0;
						state_q      <= ST_FIN;
						case (req_type)
							REQ_PUSH: begin
								if (fill_q == FULL_CNT) begin
									res_status_q <= STAT_FULL;
								end else begin
									fill_q <= fill_q + 1'b1;
								end
							end
							REQ_POP: begin
								if (fill_q == '0) begin
									res_status_q <= STAT_BAD;
								end else begin
									fill_q <= fill_q - 1'b1;
								end
							end
							REQ_CLEAR: begin
								fill_q <= '0;
							end
							REQ_ERASE_INDEX: begin
								if (pos_in_range) begin
									// move [pos+1, fill) down to pos
									src_q     <= CW'(pos_w + 1'b1);
									dst_q     <= CW'(pos_w);
									rd_pend_q <= 1'b0;
									state_q   <= ST_SHIFT;
								end else begin
									res_status_q <= STAT_BAD;
								end
							end
							REQ_ERASE_RANGE: begin
								if (range_ok) begin
									// move [end+1, fill) down to pos
									src_q     <= CW'(end_w + 1'b1);
									dst_q     <= CW'(pos_w);
									rd_pend_q <= 1'b0;
									state_q   <= ST_SHIFT;
								end else begin
									res_status_q <= STAT_BAD;
								end
							end
							REQ_READ: begin
								if (pos_in_range) begin
									// memory read issued this cycle, data lands in rdata_q
									state_q <= ST_READ;
								end else begin
									res_status_q <= STAT_BAD;
								end
							end
							default: begin
								// unused codes: no change, done status
							end
						endcase
					end
				end

				ST_READ: begin
					res_word_q <= rdata_q;
					state_q    <= ST_FIN;
				end

				ST_SHIFT: begin
					// write the word read last cycle, then advance dst
					if (rd_pend_q) begin
						dst_q <= dst_q + 1'b1;
					end
					if (src_lt) begin
						src_q     <= src_q + 1'b1;
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
					end
					// all moved: dst now sits at the new tail
					if (!src_lt && !rd_pend_q) begin
						fill_q  <= dst_q;
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload: loaded only when the output register is free, so it holds while stalled.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			status      <= res_status_q;
			read_word   <= res_word_q;
			entry_count <= 9'(fill_q);
			is_empty    <= (fill_q == '0);
		end
	end

endmodule

`default_nettype wire
